[sv/assert_macros.svh]
// Assertion macros shared by the execute unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/mcpu_pkg.sv]
// Types, opcodes, fault codes and helper functions of the execute unit.
package mcpu_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0]  opcode_t;
    typedef logic [2:0]  fault_t;
    typedef logic [1:0]  flag_t;

    localparam int unsigned STACK_REG = 15;
    localparam word_t NEWLINE_CHAR = 32'd10;

    localparam opcode_t OP_HALT  = 5'd0;
    localparam opcode_t OP_IN    = 5'd1;
    localparam opcode_t OP_OUT   = 5'd2;
    localparam opcode_t OP_LDN   = 5'd3;
    localparam opcode_t OP_ADD   = 5'd4;
    localparam opcode_t OP_SUB   = 5'd5;
    localparam opcode_t OP_MUL   = 5'd6;
    localparam opcode_t OP_DIV   = 5'd7;
    localparam opcode_t OP_ADDN  = 5'd8;
    localparam opcode_t OP_SUBN  = 5'd9;
    localparam opcode_t OP_MULN  = 5'd10;
    localparam opcode_t OP_DIVN  = 5'd11;
    localparam opcode_t OP_JMP   = 5'd12;
    localparam opcode_t OP_JMPZ  = 5'd13;
    localparam opcode_t OP_JMPNZ = 5'd14;
    localparam opcode_t OP_JMPP  = 5'd15;
    localparam opcode_t OP_JMPN  = 5'd16;
    localparam opcode_t OP_LOAD  = 5'd17;
    localparam opcode_t OP_LOADB = 5'd18;
    localparam opcode_t OP_STOR  = 5'd19;
    localparam opcode_t OP_STORB = 5'd20;
    localparam opcode_t OP_PUSH  = 5'd21;
    localparam opcode_t OP_POP   = 5'd22;
    localparam opcode_t OP_JSR   = 5'd23;
    localparam opcode_t OP_RET   = 5'd24;

    localparam fault_t FAULT_NONE     = 3'd0;
    localparam fault_t FAULT_BAD_REG  = 3'd1;
    localparam fault_t FAULT_BAD_ADDR = 3'd2;
    localparam fault_t FAULT_OVERFLOW = 3'd3;
    localparam fault_t FAULT_EMPTY    = 3'd4;
    localparam fault_t FAULT_DIV_ZERO = 3'd5;
    localparam fault_t FAULT_BAD_OP   = 3'd6;
    localparam fault_t FAULT_HALTED   = 3'd7;

    localparam flag_t FLAG_NEG  = 2'd0;
    localparam flag_t FLAG_POS  = 2'd1;
    localparam flag_t FLAG_ZERO = 2'd2;

    function automatic logic [1:0] op_words(input opcode_t op);
        logic [1:0] w;
        case (op) inside
            OP_HALT, OP_RET: w = 2'd0;
            OP_JMP, OP_JMPZ, OP_JMPNZ, OP_JMPP, OP_JMPN,
            OP_PUSH, OP_POP, OP_JSR: w = 2'd1;
            OP_IN, OP_OUT, OP_LDN, OP_LOAD, OP_STOR: w = 2'd2;
            default: w = 2'd3;
        endcase
        return w;
    endfunction

    function automatic flag_t flag_of(input word_t v);
        flag_t f;
        if (v == 32'd0) begin
            f = FLAG_ZERO;
        end else if (v[31]) begin
            f = FLAG_NEG;
        end else begin
            f = FLAG_POS;
        end
        return f;
    endfunction

endpackage

[sv/mcpu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mcpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[sv/mcpu_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module mcpu_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mcpu_pkg::word_t dividend,
    input  mcpu_pkg::word_t divisor,
    output logic           done,
    output mcpu_pkg::word_t quotient
);
    import mcpu_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    word_t       q_reg;
    word_t       r_reg;
    word_t       d_reg;
    logic        neg_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {r_reg, q_reg[31]};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            q_reg   <= dividend[31] ? (32'd0 - dividend) : dividend;
            d_reg   <= divisor[31] ? (32'd0 - divisor) : divisor;
            r_reg   <= '0;
            neg_reg <= dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            if (!diff[32]) begin
                r_reg <= diff[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= rem_sh[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - q_reg) : q_reg;
endmodule

[sv/model_cpu_execute_unit.sv]
// Execute unit of a small register machine, one instruction per transaction.
// Transactions are accepted only in S_IDLE, so the next one is taken only after the result
// is registered; the serial register reads and the 32-step divider set the time per
// instruction. Reset clears the state, pc, flag, halt state and register valid bits, not
// data memory, register contents or the result registers; unwritten registers read as zero.
`include "assert_macros.svh"
module model_cpu_execute_unit #(
    parameter int REGISTER_COUNT = 16,
    parameter int DATA_BYTES     = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  mcpu_pkg::opcode_t        s_cmd,
    input  logic signed [31:0]       s_operand_a,
    input  logic signed [31:0]       s_operand_b,
    input  logic signed [31:0]       s_operand_c,
    input  logic signed [31:0]       s_in_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_next_pc,
    output mcpu_pkg::flag_t          m_flag_state,
    output mcpu_pkg::fault_t         m_fault_code,
    output logic                     m_halted_now,
    output logic                     m_out_valid,
    output logic                     m_out_mode,
    output logic signed [31:0]       m_out_value
);
    import mcpu_pkg::*;

    localparam int RIW       = $clog2(REGISTER_COUNT);
    localparam int MEM_WORDS = DATA_BYTES / 4;
    localparam int MAW       = $clog2(MEM_WORDS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MEMRD = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_WSP   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    function automatic logic reg_ok(input word_t r);
        return r < 32'(REGISTER_COUNT);
    endfunction

    function automatic logic word_ok(input word_t a);
        return (a < 32'(DATA_BYTES)) && (a[1:0] == 2'b00);
    endfunction

    function automatic logic byte_ok(input word_t a);
        return a < 32'(DATA_BYTES);
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [2:0]          rd_cnt_reg;
    opcode_t             op_reg;
    word_t               a_reg, b_reg, c_reg, iv_reg;
    word_t               x_reg, y_reg, z_reg, sp_reg;
    logic                rd_ok_reg;
    word_t               pc_reg;
    flag_t               flag_reg;
    logic                halted_reg;
    logic [REGISTER_COUNT-1:0] rf_vld_reg;
    fault_t              fault_reg;
    logic                ov_reg, om_reg;
    word_t               oval_reg;
    logic                wb_en_reg;
    logic [RIW-1:0]      wb_idx_reg;
    word_t               wb_val_reg;
    logic                wb_flag_reg;
    flag_t               wb_fcode_reg;
    logic                sp_en_reg;
    word_t               sp_val_reg;
    word_t               maddr_reg;
    logic                m_valid_reg;
    word_t               m_pc_reg;
    flag_t               m_flag_reg;
    fault_t              m_fault_reg;
    logic                m_halt_reg;
    logic                m_ov_reg, m_om_reg;
    word_t               m_oval_reg;

    logic [RIW-1:0]      rf_raddr, rf_waddr;
    word_t               rf_rdata, rf_wdata, rf_val;
    logic                rf_we;
    logic                mem_we;
    logic [MAW-1:0]      mem_waddr;
    word_t               mem_wdata, mem_rdata;

    word_t               ysel, sp_m4, sp_p4, prod;
    fault_t              e_fault;
    logic                e_wb_en, e_wb_flag, e_sp_en, e_mem_we, e_mem_re;
    logic                e_jump, e_div, e_ov, e_om;
    logic [RIW-1:0]      e_wb_idx;
    word_t               e_wb_val, e_addr, e_mem_wdata, e_oval;
    logic                div_done;
    word_t               div_q;
    word_t               byte_val, storb_val;
    logic [4:0]          sh;
    logic                fin_go;

    mcpu_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf (
        .clk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );

    mcpu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .clk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(e_addr[MAW+1:2]), .rdata(mem_rdata)
    );

    mcpu_div u_div (
        .clk(aclk), .rst_n(aresetn), .start(state_reg == S_EXEC && e_div),
        .dividend(x_reg), .divisor(ysel), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        case (rd_cnt_reg)
            3'd0:    rf_raddr = a_reg[RIW-1:0];
            3'd1:    rf_raddr = b_reg[RIW-1:0];
            3'd2:    rf_raddr = c_reg[RIW-1:0];
            default: rf_raddr = RIW'(STACK_REG);
        endcase
    end

    assign rf_val = rd_ok_reg ? rf_rdata : 32'd0;

    assign ysel  = (op_reg >= OP_ADDN) ? b_reg : y_reg;
    assign sp_m4 = sp_reg - 32'd4;
    assign sp_p4 = sp_reg + 32'd4;
    assign prod  = x_reg * ysel;

    always_comb begin
        e_fault     = FAULT_NONE;
        e_wb_en     = 1'b0;
        e_wb_idx    = b_reg[RIW-1:0];
        e_wb_val    = a_reg;
        e_wb_flag   = 1'b0;
        e_sp_en     = 1'b0;
        e_mem_we    = 1'b0;
        e_mem_re    = 1'b0;
        e_mem_wdata = x_reg;
        e_addr      = x_reg;
        e_jump      = 1'b0;
        e_div       = 1'b0;
        e_ov        = 1'b0;
        e_om        = 1'b0;
        e_oval      = 32'd0;
        unique case (op_reg) inside
            OP_IN: begin
                if (!reg_ok(b_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (a_reg == 32'd0) begin
                    e_wb_en  = 1'b1;
                    e_wb_val = iv_reg;
                end else if (a_reg == 32'd1) begin
                    e_wb_en  = 1'b1;
                    e_wb_val = (iv_reg == NEWLINE_CHAR) ? 32'd0 : iv_reg;
                end
            end
            OP_OUT: begin
                if (!reg_ok(a_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (b_reg <= 32'd1) begin
                    e_ov   = 1'b1;
                    e_om   = b_reg[0];
                    e_oval = x_reg;
                end
            end
            OP_LDN: begin
                if (!reg_ok(b_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else begin
                    e_wb_en   = 1'b1;
                    e_wb_flag = 1'b1;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ADDN, OP_SUBN, OP_MULN, OP_DIVN: begin
                e_wb_idx = c_reg[RIW-1:0];
                case (op_reg[1:0])
                    2'd0:    e_wb_val = x_reg + ysel;
                    2'd1:    e_wb_val = x_reg - ysel;
                    default: e_wb_val = prod;
                endcase
                if (!reg_ok(a_reg) || !reg_ok(c_reg) ||
                    (op_reg < OP_ADDN && !reg_ok(b_reg))) begin
                    e_fault = FAULT_BAD_REG;
                end else if (op_reg[1:0] == 2'd3 && ysel == 32'd0) begin
                    e_fault = FAULT_DIV_ZERO;
                end else begin
                    e_wb_en   = 1'b1;
                    e_wb_flag = 1'b1;
                    e_div     = (op_reg[1:0] == 2'd3);
                end
            end
            OP_JMP:   e_jump = 1'b1;
            OP_JMPZ:  e_jump = (flag_reg == FLAG_ZERO);
            OP_JMPNZ: e_jump = (flag_reg != FLAG_ZERO);
            OP_JMPP:  e_jump = (flag_reg == FLAG_POS);
            OP_JMPN:  e_jump = (flag_reg == FLAG_NEG);
            OP_LOAD: begin
                if (!reg_ok(a_reg) || !reg_ok(b_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!word_ok(e_addr)) begin
                    e_fault = FAULT_BAD_ADDR;
                end else begin
                    e_mem_re = 1'b1;
                end
            end
            OP_LOADB: begin
                e_addr = x_reg + y_reg;
                if (!reg_ok(a_reg) || !reg_ok(b_reg) || !reg_ok(c_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!byte_ok(e_addr)) begin
                    e_fault = FAULT_BAD_ADDR;
                end else begin
                    e_mem_re = 1'b1;
                end
            end
            OP_STOR: begin
                e_addr = y_reg;
                if (!reg_ok(a_reg) || !reg_ok(b_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!word_ok(e_addr)) begin
                    e_fault = FAULT_BAD_ADDR;
                end else begin
                    e_mem_we = 1'b1;
                end
            end
            OP_STORB: begin
                e_addr = y_reg + z_reg;
                if (!reg_ok(a_reg) || !reg_ok(b_reg) || !reg_ok(c_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!byte_ok(e_addr)) begin
                    e_fault = FAULT_BAD_ADDR;
                end else begin
                    e_mem_re = 1'b1;
                end
            end
            OP_PUSH: begin
                e_addr      = sp_m4;
                e_mem_wdata = (a_reg == 32'(STACK_REG)) ? sp_m4 : x_reg;
                if (!reg_ok(a_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!word_ok(sp_m4)) begin
                    e_fault = FAULT_OVERFLOW;
                end else begin
                    e_mem_we = 1'b1;
                    e_sp_en  = 1'b1;
                end
            end
            OP_POP: begin
                e_addr = sp_reg;
                if (!reg_ok(a_reg)) begin
                    e_fault = FAULT_BAD_REG;
                end else if (!word_ok(sp_reg)) begin
                    e_fault = FAULT_EMPTY;
                end else begin
                    e_mem_re = 1'b1;
                end
            end
            OP_JSR: begin
                e_addr      = sp_m4;
                e_mem_wdata = pc_reg;
                if (!word_ok(a_reg)) begin
                    e_fault = FAULT_BAD_ADDR;
                end else if (!word_ok(sp_m4)) begin
                    e_fault = FAULT_OVERFLOW;
                end else begin
                    e_mem_we = 1'b1;
                    e_sp_en  = 1'b1;
                    e_jump   = 1'b1;
                end
            end
            OP_RET: begin
                e_addr = sp_reg;
                if (!word_ok(sp_reg)) begin
                    e_fault = FAULT_EMPTY;
                end else begin
                    e_mem_re = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign sh        = {maddr_reg[1:0], 3'b000};
    assign byte_val  = {24'd0, 8'(mem_rdata >> sh)};
    assign storb_val = (mem_rdata & ~(32'hFF << sh)) | ({24'd0, x_reg[7:0]} << sh);

    assign mem_we    = (state_reg == S_EXEC && e_mem_we) ||
                       (state_reg == S_MEMRD && op_reg == OP_STORB);
    assign mem_waddr = (state_reg == S_EXEC) ? e_addr[MAW+1:2] : maddr_reg[MAW+1:2];
    assign mem_wdata = (state_reg == S_EXEC) ? e_mem_wdata : storb_val;

    assign rf_we    = (state_reg == S_WB && wb_en_reg) || state_reg == S_WSP;
    assign rf_waddr = (state_reg == S_WSP) ? RIW'(STACK_REG) : wb_idx_reg;
    assign rf_wdata = (state_reg == S_WSP) ? sp_val_reg : wb_val_reg;

    assign fin_go = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (halted_reg || s_cmd > OP_RET || s_cmd == OP_HALT) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:  state_next = (rd_cnt_reg == 3'd4) ? S_EXEC : S_READ;
            S_EXEC: begin
                if (e_fault != FAULT_NONE) begin
                    state_next = S_FIN;
                end else if (e_div) begin
                    state_next = S_DIV;
                end else if (e_mem_re) begin
                    state_next = S_MEMRD;
                end else begin
                    state_next = S_WB;
                end
            end
            S_DIV:   state_next = div_done ? S_WB : S_DIV;
            S_MEMRD: state_next = S_WB;
            S_WB:    state_next = sp_en_reg ? S_WSP : S_FIN;
            S_WSP:   state_next = S_FIN;
            S_FIN:   state_next = fin_go ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            pc_reg      <= '0;
            flag_reg    <= FLAG_NEG;
            halted_reg  <= 1'b0;
            rf_vld_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rf_we) begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            if (state_reg == S_FIN && fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    rd_cnt_reg <= '0;
                    if (s_valid && !halted_reg) begin
                        if (s_cmd > OP_RET) begin
                            pc_reg <= pc_reg + 32'd4;
                        end else begin
                            pc_reg <= pc_reg + 32'd4 + 32'({op_words(s_cmd), 2'b00});
                        end
                    end
                end
                S_READ: rd_cnt_reg <= rd_cnt_reg + 3'd1;
                S_EXEC: begin
                    if (e_fault == FAULT_NONE && e_jump) begin
                        pc_reg <= a_reg;
                    end
                end
                S_MEMRD: begin
                    if (op_reg == OP_RET) begin
                        pc_reg <= mem_rdata;
                    end
                end
                S_WB: begin
                    if (wb_flag_reg) begin
                        flag_reg <= wb_fcode_reg;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        if (fault_reg != FAULT_NONE || op_reg == OP_HALT) begin
                            halted_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_ok_reg <= rf_vld_reg[rf_raddr];
        if (state_reg == S_IDLE && s_valid) begin
            op_reg      <= s_cmd;
            a_reg       <= s_operand_a;
            b_reg       <= s_operand_b;
            c_reg       <= s_operand_c;
            iv_reg      <= s_in_value;
            ov_reg      <= 1'b0;
            om_reg      <= 1'b0;
            oval_reg    <= 32'd0;
            wb_en_reg   <= 1'b0;
            wb_flag_reg <= 1'b0;
            sp_en_reg   <= 1'b0;
            if (halted_reg) begin
                fault_reg <= FAULT_HALTED;
            end else if (s_cmd > OP_RET) begin
                fault_reg <= FAULT_BAD_OP;
            end else begin
                fault_reg <= FAULT_NONE;
            end
        end
        if (state_reg == S_READ) begin
            case (rd_cnt_reg)
                3'd1:    x_reg  <= rf_val;
                3'd2:    y_reg  <= rf_val;
                3'd3:    z_reg  <= rf_val;
                3'd4:    sp_reg <= rf_val;
                default: ;
            endcase
        end
        if (state_reg == S_EXEC) begin
            fault_reg    <= e_fault;
            ov_reg       <= e_ov;
            om_reg       <= e_om;
            oval_reg     <= e_oval;
            wb_en_reg    <= e_wb_en && !e_mem_re;
            wb_idx_reg   <= e_wb_idx;
            wb_val_reg   <= e_wb_val;
            wb_flag_reg  <= e_wb_flag;
            wb_fcode_reg <= flag_of(e_wb_val);
            sp_en_reg    <= e_sp_en;
            sp_val_reg   <= sp_m4;
            maddr_reg    <= e_addr;
        end
        if (state_reg == S_DIV && div_done) begin
            wb_val_reg   <= div_q;
            wb_fcode_reg <= flag_of(div_q);
        end
        if (state_reg == S_MEMRD) begin
            unique case (op_reg)
                OP_LOAD: begin
                    wb_en_reg    <= 1'b1;
                    wb_idx_reg   <= b_reg[RIW-1:0];
                    wb_val_reg   <= mem_rdata;
                    wb_flag_reg  <= 1'b1;
                    wb_fcode_reg <= flag_of(mem_rdata);
                end
                OP_LOADB: begin
                    wb_en_reg    <= 1'b1;
                    wb_idx_reg   <= c_reg[RIW-1:0];
                    wb_val_reg   <= byte_val;
                    wb_flag_reg  <= 1'b1;
                    wb_fcode_reg <= flag_of(byte_val);
                end
                OP_POP: begin
                    wb_en_reg    <= 1'b1;
                    wb_idx_reg   <= a_reg[RIW-1:0];
                    wb_flag_reg  <= 1'b1;
                    wb_fcode_reg <= flag_of(mem_rdata);
                    if (a_reg == 32'(STACK_REG)) begin
                        wb_val_reg <= mem_rdata + 32'd4;
                        sp_en_reg  <= 1'b0;
                    end else begin
                        wb_val_reg <= mem_rdata;
                        sp_en_reg  <= 1'b1;
                        sp_val_reg <= sp_p4;
                    end
                end
                OP_RET: begin
                    sp_en_reg  <= 1'b1;
                    sp_val_reg <= sp_p4;
                end
                default: ;
            endcase
        end
        if (state_reg == S_FIN && fin_go) begin
            m_pc_reg    <= pc_reg;
            m_flag_reg  <= flag_reg;
            m_fault_reg <= fault_reg;
            m_halt_reg  <= halted_reg || fault_reg != FAULT_NONE || op_reg == OP_HALT;
            m_ov_reg    <= ov_reg;
            m_om_reg    <= om_reg;
            m_oval_reg  <= oval_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_next_pc    = m_pc_reg;
    assign m_flag_state = m_flag_reg;
    assign m_fault_code = m_fault_reg;
    assign m_halted_now = m_halt_reg;
    assign m_out_valid  = m_ov_reg;
    assign m_out_mode   = m_om_reg;
    assign m_out_value  = m_oval_reg;

    `ASSERT_NXT(a_halt_sticky, aclk, aresetn, halted_reg, halted_reg)
    `ASSERT_IMP(a_rf_wr_phase, aclk, aresetn, rf_we, state_reg == S_WB || state_reg == S_WSP)
    `ASSERT_IMP(a_div_in_phase, aclk, aresetn, div_done, state_reg == S_DIV)
    `ASSERT_IMP(a_halted_result, aclk, aresetn, m_valid && m_fault_code == FAULT_HALTED, m_halted_now)
endmodule

[dv/model_cpu_execute_unit_checker.sv]
// Checker for the execute unit: predicts each instruction's result and compares it.
`timescale 1ns / 1ps
module model_cpu_execute_unit_checker #(
    parameter int DATA_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  mcpu_pkg::opcode_t  s_cmd,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    input  logic signed [31:0] s_operand_c,
    input  logic signed [31:0] s_in_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_next_pc,
    input  mcpu_pkg::flag_t    m_flag_state,
    input  mcpu_pkg::fault_t   m_fault_code,
    input  logic               m_halted_now,
    input  logic               m_out_valid,
    input  logic               m_out_mode,
    input  logic signed [31:0] m_out_value,
    output int                 error_count,
    output int                 pending_count,
    output int                 checked_count
);
    import mcpu_pkg::*;

    typedef struct packed {
        word_t  pc;
        flag_t  flag;
        fault_t fault;
        logic   halted;
        logic   out_valid;
        logic   out_mode;
        word_t  out_value;
    } exec_result_t;

    word_t        regs [16];
    word_t        pc_q;
    flag_t        flag_q;
    logic         halt_q;
    word_t        data_mem [int unsigned];
    exec_result_t expected_results [$];

    initial begin
        error_count   = 0;
        checked_count = 0;
        pc_q          = '0;
        flag_q        = FLAG_NEG;
        halt_q        = 1'b0;
        foreach (regs[i]) regs[i] = '0;
    end

    assign pending_count = expected_results.size();

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned operand_words(input opcode_t op);
        int unsigned n;
        case (op)
            OP_HALT, OP_RET: n = 0;
            OP_JMP, OP_JMPZ, OP_JMPNZ, OP_JMPP, OP_JMPN, OP_PUSH, OP_POP, OP_JSR: n = 1;
            OP_IN, OP_OUT, OP_LDN, OP_LOAD, OP_STOR: n = 2;
            default: n = 3;
        endcase
        return n;
    endfunction

    function automatic logic reg_ok(input word_t r);
        return r < 16;
    endfunction

    function automatic logic word_ok(input word_t x);
        return x < DATA_BYTES && x[1:0] == 2'b00;
    endfunction

    function automatic logic byte_ok(input word_t x);
        return x < DATA_BYTES;
    endfunction

    function automatic flag_t flag_for(input word_t v);
        flag_t f;
        if (v == '0) begin
            f = FLAG_ZERO;
        end else if (v[31]) begin
            f = FLAG_NEG;
        end else begin
            f = FLAG_POS;
        end
        return f;
    endfunction

    function automatic word_t quotient(input word_t x, input word_t y);
        word_t ax;
        word_t ay;
        word_t q;
        ax = x[31] ? -x : x;
        ay = y[31] ? -y : y;
        q  = ax / ay;
        return (x[31] ^ y[31]) ? -q : q;
    endfunction

    function automatic word_t arith(input opcode_t op, input word_t x, input word_t y);
        word_t r;
        case (op)
            OP_ADD, OP_ADDN: r = x + y;
            OP_SUB, OP_SUBN: r = x - y;
            OP_MUL, OP_MULN: r = x * y;
            default:         r = quotient(x, y);
        endcase
        return r;
    endfunction

    function automatic word_t mem_read(input word_t addr);
        return data_mem.exists(addr >> 2) ? data_mem[addr >> 2] : '0;
    endfunction

    task automatic execute(input opcode_t op, input word_t a, input word_t b, input word_t c,
                           input word_t iv);
        fault_t       flt;
        word_t        sp;
        word_t        addr;
        word_t        v;
        int unsigned  sh;
        exec_result_t r;
        flt = FAULT_NONE;
        r   = '0;
        if (halt_q) begin
            flt = FAULT_HALTED;
        end else begin
            pc_q += 4;
            if (op > OP_RET) begin
                flt = FAULT_BAD_OP;
            end else begin
                pc_q += 4 * operand_words(op);
                sp = regs[STACK_REG];
                case (op)
                    OP_IN: begin
                        if (!reg_ok(b)) begin
                            flt = FAULT_BAD_REG;
                        end else if (a == 0) begin
                            regs[b] = iv;
                        end else if (a == 1) begin
                            regs[b] = (iv == NEWLINE_CHAR) ? '0 : iv;
                        end
                    end
                    OP_OUT: begin
                        if (!reg_ok(a)) begin
                            flt = FAULT_BAD_REG;
                        end else if (b <= 1) begin
                            r.out_valid = 1'b1;
                            r.out_mode  = b[0];
                            r.out_value = regs[a];
                        end
                    end
                    OP_LDN: begin
                        if (!reg_ok(b)) begin
                            flt = FAULT_BAD_REG;
                        end else begin
                            regs[b] = a;
                            flag_q  = flag_for(a);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (!reg_ok(a) || !reg_ok(b) || !reg_ok(c)) begin
                            flt = FAULT_BAD_REG;
                        end else if (op == OP_DIV && regs[b] == '0) begin
                            flt = FAULT_DIV_ZERO;
                        end else begin
                            v       = arith(op, regs[a], regs[b]);
                            regs[c] = v;
                            flag_q  = flag_for(v);
                        end
                    end
                    OP_ADDN, OP_SUBN, OP_MULN, OP_DIVN: begin
                        if (!reg_ok(a) || !reg_ok(c)) begin
                            flt = FAULT_BAD_REG;
                        end else if (op == OP_DIVN && b == '0) begin
                            flt = FAULT_DIV_ZERO;
                        end else begin
                            v       = arith(op, regs[a], b);
                            regs[c] = v;
                            flag_q  = flag_for(v);
                        end
                    end
                    OP_JMP:   pc_q = a;
                    OP_JMPZ:  if (flag_q == FLAG_ZERO) pc_q = a;
                    OP_JMPNZ: if (flag_q != FLAG_ZERO) pc_q = a;
                    OP_JMPP:  if (flag_q == FLAG_POS) pc_q = a;
                    OP_JMPN:  if (flag_q == FLAG_NEG) pc_q = a;
                    OP_LOAD: begin
                        if (!reg_ok(a) || !reg_ok(b)) begin
                            flt = FAULT_BAD_REG;
                        end else if (!word_ok(regs[a])) begin
                            flt = FAULT_BAD_ADDR;
                        end else begin
                            v       = mem_read(regs[a]);
                            regs[b] = v;
                            flag_q  = flag_for(v);
                        end
                    end
                    OP_LOADB: begin
                        if (!reg_ok(a) || !reg_ok(b) || !reg_ok(c)) begin
                            flt = FAULT_BAD_REG;
                        end else begin
                            addr = regs[a] + regs[b];
                            if (!byte_ok(addr)) begin
                                flt = FAULT_BAD_ADDR;
                            end else begin
                                v       = (mem_read(addr) >> (addr[1:0] * 8)) & 32'hFF;
                                regs[c] = v;
                                flag_q  = flag_for(v);
                            end
                        end
                    end
                    OP_STOR: begin
                        if (!reg_ok(a) || !reg_ok(b)) begin
                            flt = FAULT_BAD_REG;
                        end else if (!word_ok(regs[b])) begin
                            flt = FAULT_BAD_ADDR;
                        end else begin
                            data_mem[regs[b] >> 2] = regs[a];
                        end
                    end
                    OP_STORB: begin
                        if (!reg_ok(a) || !reg_ok(b) || !reg_ok(c)) begin
                            flt = FAULT_BAD_REG;
                        end else begin
                            addr = regs[b] + regs[c];
                            if (!byte_ok(addr)) begin
                                flt = FAULT_BAD_ADDR;
                            end else begin
                                sh = addr[1:0] * 8;
                                v  = mem_read(addr) & ~(32'hFF << sh);
                                data_mem[addr >> 2] = v | ((regs[a] & 32'hFF) << sh);
                            end
                        end
                    end
                    OP_PUSH: begin
                        if (!reg_ok(a)) begin
                            flt = FAULT_BAD_REG;
                        end else if (!word_ok(sp - 4)) begin
                            flt = FAULT_OVERFLOW;
                        end else begin
                            regs[STACK_REG] = sp - 4;
                            data_mem[(sp - 4) >> 2] = regs[a];
                        end
                    end
                    OP_POP: begin
                        if (!reg_ok(a)) begin
                            flt = FAULT_BAD_REG;
                        end else if (!word_ok(sp)) begin
                            flt = FAULT_EMPTY;
                        end else begin
                            v       = mem_read(sp);
                            regs[a] = v;
                            flag_q  = flag_for(v);
                            regs[STACK_REG] += 4;
                        end
                    end
                    OP_JSR: begin
                        if (!word_ok(a)) begin
                            flt = FAULT_BAD_ADDR;
                        end else if (!word_ok(sp - 4)) begin
                            flt = FAULT_OVERFLOW;
                        end else begin
                            regs[STACK_REG] = sp - 4;
                            data_mem[(sp - 4) >> 2] = pc_q;
                            pc_q = a;
                        end
                    end
                    OP_RET: begin
                        if (!word_ok(sp)) begin
                            flt = FAULT_EMPTY;
                        end else begin
                            pc_q = mem_read(sp);
                            regs[STACK_REG] = sp + 4;
                        end
                    end
                    default: ;
                endcase
            end
            if (flt != FAULT_NONE || op == OP_HALT) halt_q = 1'b1;
        end
        r.pc     = pc_q;
        r.flag   = flag_q;
        r.fault  = flt;
        r.halted = halt_q;
        expected_results.push_back(r);
    endtask

    // Inputs and outputs only change at the rising edge, so the falling edge
    // sees exactly what the next rising edge will accept.
    always @(negedge aclk) begin
        exec_result_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                execute(s_cmd, s_operand_a, s_operand_b, s_operand_c, s_in_value);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("result with no transaction pending, pc %h", m_next_pc));
                end else begin
                    e = expected_results.pop_front();
                    checked_count++;
                    if (m_next_pc !== e.pc)
                        report($sformatf("next_pc %h, expected %h", m_next_pc, e.pc));
                    if (m_flag_state !== e.flag)
                        report($sformatf("flag %0d, expected %0d", m_flag_state, e.flag));
                    if (m_fault_code !== e.fault)
                        report($sformatf("fault %0d, expected %0d", m_fault_code, e.fault));
                    if (m_halted_now !== e.halted)
                        report($sformatf("halted %b, expected %b", m_halted_now, e.halted));
                    if (m_out_valid !== e.out_valid)
                        report($sformatf("out_valid %b, expected %b", m_out_valid,
                                         e.out_valid));
                    if (m_out_mode !== e.out_mode)
                        report($sformatf("out_mode %b, expected %b", m_out_mode, e.out_mode));
                    if (m_out_value !== e.out_value)
                        report($sformatf("out_value %h, expected %h", m_out_value,
                                         e.out_value));
                end
            end
        end
    end

endmodule

[dv/tb_model_cpu_execute_unit.sv]
// Testbench top for the execute unit: instruction stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module tb_model_cpu_execute_unit;
    import mcpu_pkg::*;

    localparam int DATA_BYTES  = 4096;
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int GEN_REGS    = 10;
    localparam int ADDR_REG    = 12;
    localparam int OFFS_REG    = 13;
    localparam int DIVISOR_REG = 9;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    opcode_t           s_cmd;
    logic signed [31:0] s_operand_a;
    logic signed [31:0] s_operand_b;
    logic signed [31:0] s_operand_c;
    logic signed [31:0] s_in_value;
    logic              m_valid;
    logic              m_ready;
    logic signed [31:0] m_next_pc;
    flag_t             m_flag_state;
    fault_t            m_fault_code;
    logic              m_halted_now;
    logic              m_out_valid;
    logic              m_out_mode;
    logic signed [31:0] m_out_value;
    int                error_count;
    int                pending_count;
    int                checked_count;

    int          sent_count;
    int          cycle_count;
    bit          quiet;
    bit          stall_req;
    int          stack_depth;
    word_t       data_words [$];
    bit          word_written [DATA_BYTES / 8];

    model_cpu_execute_unit #(.DATA_BYTES(DATA_BYTES)) u_top (.*);

    model_cpu_execute_unit_checker #(.DATA_BYTES(DATA_BYTES)) u_checker (.*);

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                         pending_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send(input opcode_t op, input word_t a, input word_t b, input word_t c,
                        input word_t iv);
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        s_operand_c <= c;
        s_in_value  <= iv;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        sent_count++;
    endtask

    task automatic load_const(input word_t v, input int unsigned r);
        send(OP_LDN, v, r, $urandom, $urandom);
    endtask

    function automatic word_t pick_value();
        word_t v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'hFFFF_FFFF;
            4:       v = $urandom_range(0, 255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int unsigned gen_reg();
        return $urandom_range(0, GEN_REGS - 1);
    endfunction

    // Data words live below half of memory; the stack grows down from the top.
    task automatic store_word(input word_t addr, input int unsigned src);
        load_const(addr, ADDR_REG);
        send(OP_STOR, src, ADDR_REG, $urandom, $urandom);
        if (!word_written[addr >> 2]) begin
            word_written[addr >> 2] = 1'b1;
            data_words.push_back(addr);
        end
    endtask

    task automatic split_byte_addr(input word_t addr);
        word_t base;
        base = $urandom;
        load_const(base, ADDR_REG);
        load_const(addr - base, OFFS_REG);
    endtask

    task automatic random_instruction();
        opcode_t     op;
        word_t       addr;
        word_t       k;
        case ($urandom_range(0, 19))
            0, 1: load_const(pick_value(), gen_reg());
            2, 3, 4, 5: begin
                op = opcode_t'($urandom_range(OP_ADD, OP_DIV));
                if (op == OP_DIV) begin
                    k = pick_value();
                    load_const(k == 0 ? 32'd7 : k, DIVISOR_REG);
                    send(op, $urandom_range(0, 15), DIVISOR_REG, gen_reg(), $urandom);
                end else begin
                    send(op, $urandom_range(0, 15), $urandom_range(0, 15), gen_reg(), $urandom);
                end
            end
            6, 7, 8: begin
                op = opcode_t'($urandom_range(OP_ADDN, OP_DIVN));
                k  = pick_value();
                if (op == OP_DIVN && k == 0) k = 32'hFFFF_FFFF;
                send(op, $urandom_range(0, 15), k, gen_reg(), $urandom);
            end
            9: send(OP_IN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2),
                    gen_reg(), $urandom,
                    $urandom_range(0, 2) == 0 ? NEWLINE_CHAR : pick_value());
            10: send(OP_OUT, $urandom_range(0, 15),
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2),
                     $urandom, $urandom);
            11: send(opcode_t'($urandom_range(OP_JMP, OP_JMPN)), $urandom, $urandom, $urandom,
                     $urandom);
            12: store_word($urandom_range(0, DATA_BYTES / 2 / 4 - 1) * 4, gen_reg());
            13: begin
                addr = data_words[$urandom_range(0, data_words.size() - 1)]
                       + $urandom_range(0, 3);
                split_byte_addr(addr);
                send(OP_STORB, gen_reg(), ADDR_REG, OFFS_REG, $urandom);
            end
            14: begin
                load_const(data_words[$urandom_range(0, data_words.size() - 1)], ADDR_REG);
                send(OP_LOAD, ADDR_REG, gen_reg(), $urandom, $urandom);
            end
            15: begin
                addr = data_words[$urandom_range(0, data_words.size() - 1)]
                       + $urandom_range(0, 3);
                split_byte_addr(addr);
                send(OP_LOADB, ADDR_REG, OFFS_REG, gen_reg(), $urandom);
            end
            16: begin
                if (stack_depth > 0 && (stack_depth > 100 || $urandom_range(0, 1))) begin
                    send(OP_POP, gen_reg(), $urandom, $urandom, $urandom);
                    stack_depth--;
                end else begin
                    send(OP_PUSH, $urandom_range(0, 15), $urandom, $urandom, $urandom);
                    stack_depth++;
                end
            end
            17: begin
                if (stack_depth > 0 && (stack_depth > 100 || $urandom_range(0, 1))) begin
                    send(OP_RET, $urandom, $urandom, $urandom, $urandom);
                    stack_depth--;
                end else begin
                    send(OP_JSR, $urandom_range(0, DATA_BYTES / 4 - 1) * 4, $urandom,
                         $urandom, $urandom);
                    stack_depth++;
                end
            end
            default: begin
                send(OP_PUSH, STACK_REG, $urandom, $urandom, $urandom);
                send(OP_POP, STACK_REG, $urandom, $urandom, $urandom);
            end
        endcase
    endtask

    task automatic final_fault();
        case ($urandom_range(0, 6))
            0: send(OP_HALT, $urandom, $urandom, $urandom, $urandom);
            1: send(OP_LDN, $urandom, $urandom_range(16, 1000), $urandom, $urandom);
            2: begin
                load_const(DATA_BYTES - 2, ADDR_REG);
                send(OP_LOAD, ADDR_REG, 0, $urandom, $urandom);
            end
            3: begin
                load_const(0, STACK_REG);
                send(OP_PUSH, 0, $urandom, $urandom, $urandom);
            end
            4: begin
                load_const(DATA_BYTES, STACK_REG);
                send(OP_POP, 0, $urandom, $urandom, $urandom);
            end
            5: send(OP_DIVN, 0, 0, 1, $urandom);
            default: send(opcode_t'($urandom_range(OP_RET + 1, 31)), $urandom, $urandom,
                          $urandom, $urandom);
        endcase
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                stall_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int end_wait;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = OP_HALT;
        s_operand_a = '0;
        s_operand_b = '0;
        s_operand_c = '0;
        s_in_value  = '0;
        sent_count  = 0;
        quiet       = 1'b0;
        stall_req   = 1'b0;
        stack_depth = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_const(DATA_BYTES, STACK_REG);
        load_const(32'h8000_0000, 1);
        load_const(32'h7FFF_FFFF, 2);
        load_const(32'hFFFF_FFFF, 3);
        send(OP_ADD, 1, 2, 4, '0);
        send(OP_SUB, 1, 2, 5, '0);
        send(OP_MUL, 2, 2, 6, '0);
        send(OP_DIV, 1, 3, 7, '0);
        send(OP_DIVN, 1, 32'hFFFF_FFFF, 8, '0);
        send(OP_ADDN, 3, 1, 0, '0);
        send(OP_SUBN, 2, 32'h7FFF_FFFF, 0, '0);
        send(OP_JMPZ, 32'h0000_0100, '0, '0, '0);
        send(OP_MULN, 2, 32'hFFFF_FFFF, 0, '0);
        send(OP_JMPN, 32'hFFFF_FFFC, '0, '0, '0);
        send(OP_IN, 1, 4, '0, NEWLINE_CHAR);
        send(OP_IN, 0, 5, '0, 32'h8000_0000);
        send(OP_IN, 2, 6, '0, 32'h1234_5678);
        send(OP_OUT, 5, 0, '0, '0);
        send(OP_OUT, 2, 1, '0, '0);
        send(OP_OUT, 2, 3, '0, '0);
        store_word(DATA_BYTES / 2 - 4, 3);
        split_byte_addr(DATA_BYTES / 2 - 1);
        send(OP_STORB, 2, ADDR_REG, OFFS_REG, '0);
        send(OP_LOADB, ADDR_REG, OFFS_REG, 0, '0);
        load_const(DATA_BYTES / 2 - 4, ADDR_REG);
        send(OP_LOAD, ADDR_REG, 1, '0, '0);
        send(OP_PUSH, STACK_REG, '0, '0, '0);
        send(OP_POP, STACK_REG, '0, '0, '0);
        send(OP_JSR, DATA_BYTES - 4, '0, '0, '0);
        send(OP_RET, '0, '0, '0, '0);
        send(OP_JMPP, 32'h7FFF_FFFC, '0, '0, '0);
        send(OP_JMPNZ, 32'h0000_0040, '0, '0, '0);
        send(OP_JMP, 32'hFFFF_FFFF, '0, '0, '0);

        stall_req = 1'b1;
        while (sent_count < ITEM_TARGET) begin
            if (sent_count > ITEM_TARGET - 200) quiet = 1'b1;
            random_instruction();
        end

        final_fault();
        repeat (12) send(opcode_t'($urandom), $urandom, $urandom, $urandom, $urandom);
        s_valid <= 1'b0;

        end_wait = 0;
        while (pending_count != 0) @(posedge aclk);
        while (end_wait < 60) begin
            @(posedge aclk);
            end_wait++;
        end

        $display("Ran %0d instructions, %0d results compared: arithmetic, memory, stack,",
                 sent_count, checked_count);
        $display("jumps, IN/OUT, a long result stall, one terminating fault and halted replies.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
